FILE: design/triangle_element_stiffness_defines.svh
// Assertion macros shared by the stiffness block.
`ifndef TRIANGLE_ELEMENT_STIFFNESS_DEFINES_SVH
`define TRIANGLE_ELEMENT_STIFFNESS_DEFINES_SVH
// Implication checked every cycle outside reset.
`define TES_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");
// Implication whose consequent is checked in the cycle after the antecedent.
`define TES_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

FILE: design/tes_pkg.sv
package tes_pkg;
  localparam int CoordWidth  = 32;
  localparam int ResultWidth = 64;
  localparam int NumEntries  = 36;
  localparam int DiffWidth   = CoordWidth + 1;
  localparam int DetWidth    = 2 * DiffWidth + 1;
  localparam int BWidth      = DiffWidth + 1;
  localparam int DbWidth     = BWidth + 32 + 2;
  localparam int SumWidth    = BWidth + DbWidth + 2;
  localparam int NumWidth    = SumWidth + 31;
  localparam int NumAbsWidth = NumWidth + 1;
  localparam int DenWidth    = DetWidth + 2;
  localparam int QuoWidth    = NumAbsWidth;

  typedef enum logic [2:0] {
    CfgMat11 = 3'd0, CfgMat12 = 3'd1, CfgMat13 = 3'd2, CfgMat22 = 3'd3,
    CfgMat23 = 3'd4, CfgMat33 = 3'd5, CfgThick = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic signed [CoordWidth-1:0] first_x;
    logic signed [CoordWidth-1:0] first_y;
    logic signed [CoordWidth-1:0] second_x;
    logic signed [CoordWidth-1:0] second_y;
    logic signed [CoordWidth-1:0] third_x;
    logic signed [CoordWidth-1:0] third_y;
  } tri_in_t;

  typedef struct packed {
    logic [2:0]                    row_index;
    logic [2:0]                    col_index;
    logic signed [ResultWidth-1:0] stiffness_value;
    logic                          degenerate;
    logic                          last_entry;
  } stiff_out_t;

  typedef struct packed {
    logic signed [31:0] m11, m12, m13, m22, m23, m33;
    logic [30:0]        thick;
  } cfg_t;

  // Per-entry data carried through the division pipeline.
  typedef struct packed {
    logic [2:0]           row;
    logic [2:0]           col;
    logic                 degen;
    logic                 last;
    logic                 neg;
    logic [NumAbsWidth-1:0] num;
    logic [DenWidth-1:0]  den;
  } ent_t;
endpackage

FILE: design/tes_geom.sv
// Per-triangle front end: differences, determinant, B0 and D*B0, then entry
// sequencing. Each entry's B0 column dot D*B0 column is formed and scaled.
module tes_geom (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  tes_pkg::tri_in_t in_data_i,
  input  tes_pkg::cfg_t   cfg_i,
  output logic            ent_valid_o,
  input  logic            ent_ready_i,
  output tes_pkg::ent_t   ent_o
);
  import tes_pkg::*;

  localparam int SliceW = SumWidth / 4;
  localparam int TpW    = SliceW + 33;

  // Stage 1: differences.
  logic                        s1_v_q;
  logic signed [DiffWidth-1:0] a_q, b_q, c_q, d_q;
  // Stage 2: determinant and B0.
  logic                        s2_v_q;
  logic signed [DetWidth-1:0]  det_q;
  logic signed [BWidth-1:0]    bm_q [3][6];
  // Stage 3: D*B0 and denominator; held for the 36-entry walk.
  logic                        s3_v_q;
  logic signed [DbWidth-1:0]   db_q [3][6];
  logic signed [BWidth-1:0]    bh_q [3][6];
  logic [DenWidth-1:0]         den_q;
  logic                        degen_q;
  logic [2:0]                  row_q, col_q;
  // Stage 4: partial products of one entry, D*B0 split into a low and a high half.
  logic                        s4_v_q;
  logic signed [2*BWidth:0]    lo4_q [3];
  logic signed [2*BWidth-1:0]  hi4_q [3];
  logic [2:0]                  r4_q, c4_q;
  logic                        l4_q, dg4_q;
  logic [DenWidth-1:0]         den4_q;
  // Stage 5: dot product of one entry.
  logic                        s5_v_q;
  logic signed [SumWidth-1:0]  sum_q;
  logic [2:0]                  r5_q, c5_q;
  logic                        l5_q, dg5_q;
  logic [DenWidth-1:0]         den5_q;
  // Stage 6: four slices of the dot product times thickness.
  logic                        s6_v_q;
  logic signed [TpW-1:0]       tp6_q [4];
  logic [2:0]                  r6_q, c6_q;
  logic                        l6_q, dg6_q;
  logic [DenWidth-1:0]         den6_q;
  // Stage 7: scaled dot product.
  logic                        s7_v_q;
  logic signed [NumWidth-1:0]  prod_q;
  logic [2:0]                  r7_q, c7_q;
  logic                        l7_q, dg7_q;
  logic [DenWidth-1:0]         den7_q;

  logic s7_ready, s6_ready, s5_ready, s4_ready, walk_last, s3_adv, s2_ready, s1_ready;
  logic signed [DetWidth-1:0] det_d;
  logic signed [SumWidth-1:0] sum_d;
  logic signed [NumWidth-1:0] prod_d;
  logic [DetWidth-1:0] det_abs;
  logic signed [31:0] dmat [3][3];
  logic signed [31:0] thick_s;

  assign s7_ready  = !s7_v_q || ent_ready_i;
  assign s6_ready  = !s6_v_q || s7_ready;
  assign s5_ready  = !s5_v_q || s6_ready;
  assign s4_ready  = !s4_v_q || s5_ready;
  assign walk_last = (row_q == 3'd5) && (col_q == 3'd5);
  assign s3_adv    = s3_v_q && s4_ready;
  assign s2_ready  = !s3_v_q || (s3_adv && walk_last);
  assign s1_ready  = !s2_v_q || s2_ready;
  assign in_ready_o = !s1_v_q || s1_ready;
  assign thick_s   = $signed({1'b0, cfg_i.thick});

  always_comb begin
    dmat[0][0] = cfg_i.m11; dmat[0][1] = cfg_i.m12; dmat[0][2] = cfg_i.m13;
    dmat[1][0] = cfg_i.m12; dmat[1][1] = cfg_i.m22; dmat[1][2] = cfg_i.m23;
    dmat[2][0] = cfg_i.m13; dmat[2][1] = cfg_i.m23; dmat[2][2] = cfg_i.m33;
    det_d = DetWidth'(a_q * d_q) - DetWidth'(b_q * c_q);
    det_abs = det_q[DetWidth-1] ? DetWidth'(-det_q) : DetWidth'(det_q);
    sum_d = '0;
    for (int k = 0; k < 3; k++) begin
      sum_d = sum_d + (SumWidth'(hi4_q[k]) <<< BWidth) + SumWidth'(lo4_q[k]);
    end
    prod_d = NumWidth'(tp6_q[0])
           + (NumWidth'(tp6_q[1]) <<< SliceW)
           + (NumWidth'(tp6_q[2]) <<< (2 * SliceW))
           + (NumWidth'(tp6_q[3]) <<< (3 * SliceW));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0; s2_v_q <= 1'b0; s3_v_q <= 1'b0;
      s4_v_q <= 1'b0; s5_v_q <= 1'b0; s6_v_q <= 1'b0; s7_v_q <= 1'b0;
      row_q <= '0; col_q <= '0;
    end else begin
      if (in_ready_o) s1_v_q <= in_valid_i;
      if (s1_ready) s2_v_q <= s1_v_q;
      if (s2_ready) begin
        s3_v_q <= s2_v_q;
        row_q <= '0; col_q <= '0;
      end else if (s3_adv) begin
        if (col_q == 3'd5) begin
          col_q <= '0; row_q <= row_q + 3'd1;
        end else begin
          col_q <= col_q + 3'd1;
        end
      end
      if (s4_ready) s4_v_q <= s3_v_q;
      if (s5_ready) s5_v_q <= s4_v_q;
      if (s6_ready) s6_v_q <= s5_v_q;
      if (s7_ready) s7_v_q <= s6_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      a_q <= DiffWidth'(in_data_i.first_x) - DiffWidth'(in_data_i.third_x);
      b_q <= DiffWidth'(in_data_i.first_y) - DiffWidth'(in_data_i.third_y);
      c_q <= DiffWidth'(in_data_i.second_x) - DiffWidth'(in_data_i.third_x);
      d_q <= DiffWidth'(in_data_i.second_y) - DiffWidth'(in_data_i.third_y);
    end
    if (s1_ready && s1_v_q) begin
      det_q <= det_d;
      bm_q[0][1] <= '0; bm_q[0][3] <= '0; bm_q[0][5] <= '0;
      bm_q[1][0] <= '0; bm_q[1][2] <= '0; bm_q[1][4] <= '0;
      bm_q[0][0] <= BWidth'(d_q);      bm_q[0][2] <= -BWidth'(b_q);
      bm_q[0][4] <= BWidth'(b_q) - BWidth'(d_q);
      bm_q[1][1] <= -BWidth'(c_q);     bm_q[1][3] <= BWidth'(a_q);
      bm_q[1][5] <= BWidth'(c_q) - BWidth'(a_q);
      bm_q[2][0] <= -BWidth'(c_q);     bm_q[2][1] <= BWidth'(d_q);
      bm_q[2][2] <= BWidth'(a_q);      bm_q[2][3] <= -BWidth'(b_q);
      bm_q[2][4] <= BWidth'(c_q) - BWidth'(a_q);
      bm_q[2][5] <= BWidth'(b_q) - BWidth'(d_q);
    end
    if (s2_ready && s2_v_q) begin
      for (int k = 0; k < 3; k++) begin
        for (int j = 0; j < 6; j++) begin
          db_q[k][j] <= DbWidth'(dmat[k][0] * bm_q[0][j])
                      + DbWidth'(dmat[k][1] * bm_q[1][j])
                      + DbWidth'(dmat[k][2] * bm_q[2][j]);
          bh_q[k][j] <= bm_q[k][j];
        end
      end
      den_q   <= {1'b0, det_abs, 1'b0};
      degen_q <= (det_q == '0);
    end
    if (s4_ready && s3_v_q) begin
      for (int k = 0; k < 3; k++) begin
        lo4_q[k] <= bh_q[k][row_q] * $signed({1'b0, db_q[k][col_q][BWidth-1:0]});
        hi4_q[k] <= bh_q[k][row_q] * $signed(db_q[k][col_q][DbWidth-1:BWidth]);
      end
      r4_q <= row_q; c4_q <= col_q; l4_q <= walk_last;
      den4_q <= den_q; dg4_q <= degen_q;
    end
    if (s5_ready && s4_v_q) begin
      sum_q <= sum_d;
      r5_q <= r4_q; c5_q <= c4_q; l5_q <= l4_q; den5_q <= den4_q; dg5_q <= dg4_q;
    end
    if (s6_ready && s5_v_q) begin
      tp6_q[0] <= $signed({1'b0, sum_q[SliceW-1:0]}) * thick_s;
      tp6_q[1] <= $signed({1'b0, sum_q[2*SliceW-1:SliceW]}) * thick_s;
      tp6_q[2] <= $signed({1'b0, sum_q[3*SliceW-1:2*SliceW]}) * thick_s;
      tp6_q[3] <= $signed(sum_q[SumWidth-1:3*SliceW]) * thick_s;
      r6_q <= r5_q; c6_q <= c5_q; l6_q <= l5_q; den6_q <= den5_q; dg6_q <= dg5_q;
    end
    if (s7_ready && s6_v_q) begin
      prod_q <= prod_d;
      r7_q <= r6_q; c7_q <= c6_q; l7_q <= l6_q; den7_q <= den6_q; dg7_q <= dg6_q;
    end
  end

  logic [NumWidth-1:0] pabs;
  assign pabs = prod_q[NumWidth-1] ? NumWidth'(-prod_q) : NumWidth'(prod_q);
  assign ent_valid_o   = s7_v_q;
  assign ent_o.row     = r7_q;
  assign ent_o.col     = c7_q;
  assign ent_o.last    = l7_q;
  assign ent_o.degen   = dg7_q;
  assign ent_o.neg     = prod_q[NumWidth-1];
  assign ent_o.den     = den7_q;
  // Rounded quotient: (2|s| + den) / (2 den), numerator carried as 2|s|+den.
  assign ent_o.num     = {pabs, 1'b0} + NumAbsWidth'(den7_q);
endmodule

FILE: design/tes_div.sv
// Pipelined restoring divider, one quotient bit per stage, then saturation.
module tes_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              ent_valid_i,
  output logic              ent_ready_o,
  input  tes_pkg::ent_t     ent_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output tes_pkg::stiff_out_t out_data_o
);
  import tes_pkg::*;

  localparam int Steps = QuoWidth;
  localparam int RemW  = DenWidth + 2;

  logic                  v_q   [Steps+1];
  ent_t                  e_q   [Steps+1];
  logic [RemW-1:0]       rem_q [Steps+1];
  logic [QuoWidth-1:0]   quo_q [Steps+1];
  logic                  rdy   [Steps+1];
  stiff_out_t            out_q;
  logic                  ov_q;

  logic [ResultWidth-1:0] maxpos;
  assign maxpos = {1'b0, {(ResultWidth-1){1'b1}}};

  assign rdy[Steps] = !ov_q || out_ready_i;
  for (genvar s = 0; s < Steps; s++) begin : g_rdy
    assign rdy[s] = !v_q[s] || rdy[s+1];
  end
  assign ent_ready_o = rdy[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s <= Steps; s++) v_q[s] <= 1'b0;
      ov_q <= 1'b0;
    end else begin
      if (rdy[0]) v_q[0] <= ent_valid_i;
      for (int s = 1; s <= Steps; s++) if (rdy[s]) v_q[s] <= v_q[s-1];
      if (rdy[Steps]) ov_q <= v_q[Steps];
    end
  end

  // Divisor is 2*den.
  always_ff @(posedge clk_i) begin
    logic [RemW-1:0] r;
    logic [RemW-1:0] dv;
    logic [ResultWidth-1:0] mag;
    logic big;
    if (rdy[0] && ent_valid_i) begin
      e_q[0] <= ent_i; rem_q[0] <= '0; quo_q[0] <= '0;
    end
    for (int s = 1; s <= Steps; s++) begin
      if (rdy[s] && v_q[s-1]) begin
        dv = {1'b0, e_q[s-1].den, 1'b0};
        r  = {rem_q[s-1][RemW-2:0], e_q[s-1].num[Steps-s]};
        e_q[s] <= e_q[s-1];
        if (r >= dv) begin
          rem_q[s] <= r - dv;
          quo_q[s] <= quo_q[s-1] | (QuoWidth'(1) << (Steps - s));
        end else begin
          rem_q[s] <= r;
          quo_q[s] <= quo_q[s-1];
        end
      end
    end
    if (rdy[Steps] && v_q[Steps]) begin
      big = |(quo_q[Steps] >> ResultWidth);
      mag = quo_q[Steps][ResultWidth-1:0];
      out_q.row_index  <= e_q[Steps].row;
      out_q.col_index  <= e_q[Steps].col;
      out_q.degenerate <= e_q[Steps].degen;
      out_q.last_entry <= e_q[Steps].last;
      if (e_q[Steps].degen) begin
        out_q.stiffness_value <= '0;
      end else if (e_q[Steps].neg) begin
        if (big || mag > maxpos + 1'b1) out_q.stiffness_value <= -(maxpos + 1'b1);
        else out_q.stiffness_value <= -mag;
      end else begin
        if (big || mag > maxpos) out_q.stiffness_value <= maxpos;
        else out_q.stiffness_value <= mag;
      end
    end
  end

  assign out_valid_o = ov_q;
  assign out_data_o  = out_q;
endmodule

FILE: design/triangle_element_stiffness.sv
// Constant-strain triangle stiffness engine.
// Input channel: one transfer carries three node coordinates (signed Q16.16).
// Output channel: each triangle yields 36 transfers, the 6x6 stiffness matrix
// row-major in signed Q32.32, saturated, last_entry marking the 36th.
// A zero determinant gives 36 zero entries with degenerate set.
// Configuration: plain write port, index 0..5 the material matrix, 6 thickness;
// write only while the block is idle.
// Throughput: one entry per cycle while the receiver is ready; the next triangle
// waits in the front stages until the 36-step entry walk over the held B0 and D*B0 is through.
// Path: seven front-end register stages, then the divider's input register,
// its 136 quotient stages and its output register.
// Reset clears all valid bits and loads the register defaults (thickness 1.0).
// When the receiver stalls, every stage that holds an entry keeps it; no entry is lost or repeated.
module triangle_element_stiffness (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  tes_pkg::tri_in_t     in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output tes_pkg::stiff_out_t  out_data_o,
  input  logic                 cfg_we_i,
  input  logic [2:0]           cfg_idx_i,
  input  logic [31:0]          cfg_data_i
);
  import tes_pkg::*;
  `include "triangle_element_stiffness_defines.svh"

  cfg_t cfg_q;
  logic ent_valid, ent_ready;
  ent_t ent;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{m11: '0, m12: '0, m13: '0, m22: '0, m23: '0, m33: '0,
                 thick: 31'd65536};
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CfgMat11: cfg_q.m11   <= cfg_data_i;
        CfgMat12: cfg_q.m12   <= cfg_data_i;
        CfgMat13: cfg_q.m13   <= cfg_data_i;
        CfgMat22: cfg_q.m22   <= cfg_data_i;
        CfgMat23: cfg_q.m23   <= cfg_data_i;
        CfgMat33: cfg_q.m33   <= cfg_data_i;
        CfgThick: cfg_q.thick <= cfg_data_i[30:0];
        default: ;
      endcase
    end
  end

  tes_geom u_geom (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_data_i,
    .cfg_i(cfg_q), .ent_valid_o(ent_valid), .ent_ready_i(ent_ready), .ent_o(ent)
  );

  tes_div u_div (
    .clk_i, .rst_ni, .ent_valid_i(ent_valid), .ent_ready_o(ent_ready),
    .ent_i(ent), .out_valid_o, .out_ready_i, .out_data_o
  );

  `TES_ASSERT_IMP(a_idx_range, clk_i, rst_ni, out_valid_o,
    out_data_o.row_index <= 3'd5 && out_data_o.col_index <= 3'd5)
  `TES_ASSERT_IMP(a_last_pos, clk_i, rst_ni, out_valid_o && out_data_o.last_entry,
    out_data_o.row_index == 3'd5 && out_data_o.col_index == 3'd5)
  `TES_ASSERT_IMP(a_degen_zero, clk_i, rst_ni, out_valid_o && out_data_o.degenerate,
    out_data_o.stiffness_value == '0)
  `TES_ASSERT_NEXT(a_hold, clk_i, rst_ni, out_valid_o && !out_ready_i,
    out_valid_o && $stable(out_data_o))
endmodule

FILE: test/tb_triangle_element_stiffness.sv
module tb_triangle_element_stiffness;
  timeunit 1ns;
  timeprecision 1ps;
  import tes_pkg::*;

  // The widest exact intermediate (coordinates, products, thickness) fits well
  // within 256 bits, so the predictor does its arithmetic in one signed vector.
  typedef logic signed [255:0] big_t;

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_ready_o;
  tri_in_t    in_data_i;
  logic       out_valid_o;
  logic       out_ready_i;
  stiff_out_t out_data_o;
  logic       cfg_we_i;
  logic [2:0] cfg_idx_i;
  logic [31:0] cfg_data_i;

  // The predictor keeps its own copy of the material matrix and thickness.
  logic signed [31:0] mat_q [6];
  logic [30:0]        thick_q;

  stiff_out_t expected_entries [$];
  int  error_count;
  // When set, both sides run without any idle gaps.
  bit  no_idle;

  triangle_element_stiffness u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // The run ends here if the block stops making progress.
  initial begin
    #20ms;
    $display("tb_triangle_element_stiffness: done, errors");
    $finish;
  end

  // Computes the 36 entries of t/(2|det|) * B0^T D B0 for one triangle and
  // queues them in row-major order.
  task automatic predict_stiffness(input tri_in_t tri_item);
    big_t a, b, c, d, det, den, s, num, q, maxpos, minmag;
    big_t bm [3][6];
    big_t dm [3][3];
    big_t db [3][6];
    bit degen, neg;
    stiff_out_t e;
    a = big_t'(tri_item.first_x) - big_t'(tri_item.third_x);
    b = big_t'(tri_item.first_y) - big_t'(tri_item.third_y);
    c = big_t'(tri_item.second_x) - big_t'(tri_item.third_x);
    d = big_t'(tri_item.second_y) - big_t'(tri_item.third_y);
    det = a * d - b * c;
    degen = (det == 0);
    den = (det < 0) ? -det : det;
    den = 2 * den;
    for (int k = 0; k < 3; k++)
      for (int j = 0; j < 6; j++)
        bm[k][j] = '0;
    bm[0][0] = d;  bm[0][2] = -b; bm[0][4] = b - d;
    bm[1][1] = -c; bm[1][3] = a;  bm[1][5] = c - a;
    bm[2][0] = -c; bm[2][1] = d;  bm[2][2] = a;
    bm[2][3] = -b; bm[2][4] = c - a; bm[2][5] = b - d;
    dm[0][0] = big_t'(mat_q[0]); dm[0][1] = big_t'(mat_q[1]); dm[0][2] = big_t'(mat_q[2]);
    dm[1][0] = dm[0][1];        dm[1][1] = big_t'(mat_q[3]); dm[1][2] = big_t'(mat_q[4]);
    dm[2][0] = dm[0][2];        dm[2][1] = dm[1][2];        dm[2][2] = big_t'(mat_q[5]);
    for (int k = 0; k < 3; k++)
      for (int j = 0; j < 6; j++) begin
        db[k][j] = '0;
        for (int l = 0; l < 3; l++) db[k][j] += dm[k][l] * bm[l][j];
      end
    maxpos = (big_t'(1) <<< 63) - 1;
    minmag = big_t'(1) <<< 63;
    for (int i = 0; i < 6; i++)
      for (int j = 0; j < 6; j++) begin
        e = '0;
        e.row_index = i[2:0];
        e.col_index = j[2:0];
        e.degenerate = degen;
        e.last_entry = (i == 5 && j == 5);
        if (!degen) begin
          s = '0;
          for (int k = 0; k < 3; k++) s += bm[k][i] * db[k][j];
          s = s * big_t'({1'b0, thick_q});
          neg = (s < 0);
          num = neg ? -s : s;
          // Round to nearest with ties away from zero: (2n + den) / (2 den).
          q = (2 * num + den) / (2 * den);
          if (neg) begin
            if (q > minmag) q = minmag;
            e.stiffness_value = -q[63:0];
          end else begin
            if (q > maxpos) q = maxpos;
            e.stiffness_value = q[63:0];
          end
        end
        expected_entries.push_back(e);
      end
  endtask

  // Compares each output transfer with the oldest expectation.
  always @(posedge clk_i) begin
    stiff_out_t exp_e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_entries.size() == 0) begin
        $display("%0t: unexpected entry, expected none, actual %p", $time, out_data_o);
        error_count++;
      end else begin
        exp_e = expected_entries.pop_front();
        if (out_data_o.row_index !== exp_e.row_index) begin
          $display("%0t: row_index expected %0d actual %0d", $time,
                   exp_e.row_index, out_data_o.row_index);
          error_count++;
        end
        if (out_data_o.col_index !== exp_e.col_index) begin
          $display("%0t: col_index expected %0d actual %0d", $time,
                   exp_e.col_index, out_data_o.col_index);
          error_count++;
        end
        if (out_data_o.stiffness_value !== exp_e.stiffness_value) begin
          $display("%0t: stiffness_value expected %h actual %h", $time,
                   exp_e.stiffness_value, out_data_o.stiffness_value);
          error_count++;
        end
        if (out_data_o.degenerate !== exp_e.degenerate) begin
          $display("%0t: degenerate expected %b actual %b", $time,
                   exp_e.degenerate, out_data_o.degenerate);
          error_count++;
        end
        if (out_data_o.last_entry !== exp_e.last_entry) begin
          $display("%0t: last_entry expected %b actual %b", $time,
                   exp_e.last_entry, out_data_o.last_entry);
          error_count++;
        end
      end
    end
  end

  // The receiver stalls in random bursts.
  initial begin
    int gap;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (!no_idle && $urandom_range(0, 5) == 0 && gap == 0) begin
        gap = $urandom_range(1, 7);
      end
      if (gap > 0) begin
        out_ready_i <= 1'b0;
        gap--;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Sends one triangle, with an occasional random idle burst before it.
  // Valid stays high after the transfer so the next triangle can follow at once.
  task automatic send_triangle(input tri_in_t tri_item);
    int gap;
    if (!no_idle && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 7);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= tri_item;
    do @(posedge clk_i); while (!in_ready_o);
    predict_stiffness(tri_item);
  endtask

  // Waits until every expected entry has arrived, then lets the divider
  // pipeline drain fully before the configuration changes.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (expected_entries.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [31:0] value);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CfgMat11: mat_q[0] = value;
      CfgMat12: mat_q[1] = value;
      CfgMat13: mat_q[2] = value;
      CfgMat22: mat_q[3] = value;
      CfgMat23: mat_q[4] = value;
      CfgMat33: mat_q[5] = value;
      CfgThick: thick_q = value[30:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic write_material(input logic [31:0] m11, m12, m13, m22, m23, m33,
                                input logic [31:0] thick);
    write_reg(CfgMat11, m11);
    write_reg(CfgMat12, m12);
    write_reg(CfgMat13, m13);
    write_reg(CfgMat22, m22);
    write_reg(CfgMat23, m23);
    write_reg(CfgMat33, m33);
    write_reg(CfgThick, thick);
  endtask

  function automatic tri_in_t make_tri(input int x1, y1, x2, y2, x3, y3);
    tri_in_t t;
    t.first_x = x1;  t.first_y = y1;
    t.second_x = x2; t.second_y = y2;
    t.third_x = x3;  t.third_y = y3;
    return t;
  endfunction

  // A random coordinate: mostly modest values, sometimes any 32-bit pattern.
  function automatic logic [31:0] rand_coord();
    if ($urandom_range(0, 4) == 0) return $urandom();
    return $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
  endfunction

  // Default registers (zero material) give all-zero but non-degenerate entries.
  task automatic test_reset_defaults();
    send_triangle(make_tri(0, 0, 32'h0001_0000, 0, 0, 32'h0001_0000));
    wait_idle();
  endtask

  // Directed triangles: counterclockwise, clockwise, degenerate, and extremes.
  task automatic test_directed();
    // Isotropic-like material in Q16.16.
    write_material(32'h0010_0000, 32'h0004_0000, 32'h0000_8000, 32'h0010_0000,
                   32'hFFFF_8000, 32'h0006_0000, 32'h0001_0000);
    send_triangle(make_tri(0, 0, 32'h0001_0000, 0, 0, 32'h0001_0000));
    // Same triangle with clockwise node order.
    send_triangle(make_tri(0, 0, 0, 32'h0001_0000, 32'h0001_0000, 0));
    // Collinear nodes give a zero determinant.
    send_triangle(make_tri(0, 0, 32'h0001_0000, 32'h0001_0000,
                           32'h0002_0000, 32'h0002_0000));
    // All three nodes on one point.
    send_triangle(make_tri(5, 5, 5, 5, 5, 5));
    // Tiny triangle with legs of one LSB.
    send_triangle(make_tri(0, 0, 1, 0, 0, 1));
    // Coordinates at the extremes of the field range.
    send_triangle(make_tri(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                           32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF));
    send_triangle(make_tri(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                           32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000));
    send_triangle(make_tri(-1, -1, -1, 0, 0, -1));
    wait_idle();
    // Extreme material entries and thickness, positive and negative.
    write_material(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                   32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
    send_triangle(make_tri(0, 0, 1, 0, 0, 1));
    send_triangle(make_tri(0, 0, 32'h0003_0000, 32'h0000_4000, 32'h0000_8000,
                           32'h0002_0000));
    send_triangle(make_tri(32'h8000_0000, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                           0, 32'h8000_0000));
    wait_idle();
    // Zero thickness, and a register write with the unused top bit set.
    write_material(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                   32'h8000_0000, 32'h8000_0000, 32'h0000_0000);
    send_triangle(make_tri(0, 0, 32'h0001_0000, 0, 0, 32'h0001_0000));
    wait_idle();
    write_reg(CfgThick, 32'hFFFF_FFFF);
    send_triangle(make_tri(0, 0, 32'h0001_0000, 0, 0, 32'h0001_0000));
    send_triangle(make_tri(32'h0001_0000, 32'h0002_0000, 32'hFFFF_0000,
                           32'h0000_8000, 32'h0000_1234, 32'hFFFE_0000));
    wait_idle();
  endtask

  // Random triangles under several random material settings; a few are
  // made collinear on purpose so the degenerate path keeps being hit.
  task automatic test_random(input int count);
    tri_in_t t;
    int s;
    for (int n = 0; n < count; n++) begin
      if (n % 60 == 0) begin
        wait_idle();
        write_material($urandom(), $urandom(), $urandom(), $urandom(),
                       $urandom(), $urandom(), $urandom());
      end
      t = make_tri(rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                   rand_coord(), rand_coord());
      if ($urandom_range(0, 9) == 0) begin
        // Second node on the line through the first and third.
        s = $urandom_range(0, 3);
        t.second_x = t.third_x + s * (t.first_x - t.third_x);
        t.second_y = t.third_y + s * (t.first_y - t.third_y);
      end
      send_triangle(t);
    end
    wait_idle();
  endtask

  // The last stretch runs back to back with the receiver always ready.
  task automatic test_back_to_back(input int count);
    no_idle = 1'b1;
    write_material($urandom(), $urandom(), $urandom(), $urandom(),
                   $urandom(), $urandom(), 32'h0001_0000);
    for (int n = 0; n < count; n++)
      send_triangle(make_tri(rand_coord(), rand_coord(), rand_coord(),
                             rand_coord(), rand_coord(), rand_coord()));
    in_valid_i <= 1'b0;
  endtask

  initial begin
    int guard;
    error_count = 0;
    no_idle     = 1'b0;
    for (int i = 0; i < 6; i++) mat_q[i] = '0;
    thick_q    = 31'd65536;
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    in_data_i  = '0;
    cfg_we_i   = 1'b0;
    cfg_idx_i  = CfgMat11;
    cfg_data_i = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_defaults();
    test_directed();
    test_random(310);
    test_back_to_back(45);

    guard = 0;
    while (expected_entries.size() != 0 && guard < 200000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (200) @(posedge clk_i);
    if (error_count == 0 && expected_entries.size() == 0) begin
      $display("tb_triangle_element_stiffness: done, clean");
    end else begin
      $display("tb_triangle_element_stiffness: done, errors");
    end
    $finish;
  end

endmodule
